// File: rtl/evch_pkg.sv
// Package for the event channel pending and dispatch block.
// Holds operation codes, fixed field widths and the controller/datapath structs.
// No dependencies.
package evch_pkg;

    localparam int OP_W       = 3;
    localparam int PORT_W     = 6;
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = 2;

    localparam logic [OP_W-1:0] OP_RAISE      = 3'd0;
    localparam logic [OP_W-1:0] OP_MASK       = 3'd1;
    localparam logic [OP_W-1:0] OP_UNMASK     = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPATCH   = 3'd4;
    localparam logic [OP_W-1:0] OP_UPCALL_SET = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // Execute the accepted word.
        logic emit;   // Emit the lowest active port of the dispatch run.
    } evch_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // Output register empty or being taken this cycle.
        logic is_dispatch;  // Incoming word is a dispatch.
        logic start_empty;  // Dispatch would deliver no port.
        logic last_pick;    // Port picked now is the last of the run.
    } evch_sts_t;

endpackage

// File: rtl/event_channel_pending_dispatch.sv
// Event channel pending and dispatch block. A word is accepted whenever the
// block is idle and its output register is empty or being drained; raise,
// mask, unmask, clear and upcall mask words load their single result into the
// output register at the accepting edge, so with the result side ready a new
// word is taken every cycle. A dispatch snapshots the pending,
// unmasked ports of the selected groups and then, while the output register
// is free, hands out one port per cycle, lowest first, through a single
// find-first-set on the run vector; the next word is taken once the last
// port of the run sits in the output register.
// Depends on evch_pkg, evch_ctrl and evch_datapath.
module event_channel_pending_dispatch #(
    parameter int NUM_PORTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [evch_pkg::OP_W-1:0]        s_operation,
    input  logic [evch_pkg::PORT_W-1:0]      s_event_port,
    input  logic                             s_mask_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [evch_pkg::PORT_W-1:0]      m_dispatched_port,
    output logic                             m_port_valid,
    output logic                             m_callback_request,
    output logic                             m_last_of_run
);

    evch_pkg::evch_cmd_t cmd;
    evch_pkg::evch_sts_t sts;

    evch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    evch_datapath #(
        .NUM_PORTS (NUM_PORTS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_operation        (s_operation),
        .s_event_port       (s_event_port),
        .s_mask_level       (s_mask_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_dispatched_port  (m_dispatched_port),
        .m_port_valid       (m_port_valid),
        .m_callback_request (m_callback_request),
        .m_last_of_run      (m_last_of_run),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

// File: rtl/evch_ctrl.sv
// Controller for the event channel block: idle/run state machine.
// Depends on evch_pkg for the command and status structs.
module evch_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  evch_pkg::evch_sts_t sts,
    output evch_pkg::evch_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    cmd.exec = 1'b1;
                    if (sts.is_dispatch && !sts.start_empty) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_pick) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/evch_datapath.sv
// Datapath for the event channel block: port bits, selector, upcall flags,
// dispatch run vector and the output register. Depends on evch_pkg.
module evch_datapath #(
    parameter int NUM_PORTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [evch_pkg::OP_W-1:0]        s_operation,
    input  logic [evch_pkg::PORT_W-1:0]      s_event_port,
    input  logic                             s_mask_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [evch_pkg::PORT_W-1:0]      m_dispatched_port,
    output logic                             m_port_valid,
    output logic                             m_callback_request,
    output logic                             m_last_of_run,
    input  evch_pkg::evch_cmd_t              cmd,
    output evch_pkg::evch_sts_t              sts
);

    localparam logic [evch_pkg::PORT_W:0] PORT_LIMIT = (evch_pkg::PORT_W + 1)'(NUM_PORTS);

    logic [NUM_PORTS-1:0] pending_reg, pending_next;
    logic [NUM_PORTS-1:0] mask_reg, mask_next;
    logic [NUM_PORTS-1:0] active_reg, active_next;
    logic [1:0]           sel_reg, sel_next;
    logic                 upcall_pend_reg, upcall_pend_next;
    logic                 upcall_masked_reg, upcall_masked_next;

    logic                        out_valid_reg, out_valid_next;
    logic [evch_pkg::PORT_W-1:0] out_port_reg, out_port_next;
    logic                        out_pv_reg, out_pv_next;
    logic                        out_cb_reg, out_cb_next;
    logic                        out_last_reg, out_last_next;

    logic                        port_ok;
    logic [NUM_PORTS-1:0]        port_bit;
    logic [NUM_PORTS-1:0]        grp_mask;
    logic [NUM_PORTS-1:0]        snapshot;
    logic [NUM_PORTS-1:0]        lowest_oh;
    logic [evch_pkg::PORT_W-1:0] pick_idx;
    logic                        gsel;
    logic                        latch_cb;
    logic                        latch_new;

    assign port_ok  = {1'b0, s_event_port} < PORT_LIMIT;
    assign port_bit = port_ok ? (NUM_PORTS'(1) << s_event_port) : '0;
    assign gsel     = s_event_port[evch_pkg::PORT_W-1];

    // Ports below the group size belong to group 0, the rest to group 1.
    always_comb begin
        for (int i = 0; i < NUM_PORTS; i++) begin
            grp_mask[i] = (i < evch_pkg::GROUP_SIZE) ? sel_reg[0] : sel_reg[1];
        end
    end

    assign snapshot = pending_reg & ~mask_reg & grp_mask;

    // Lowest set bit of the run vector, then its index.
    assign lowest_oh = active_reg & (~active_reg + NUM_PORTS'(1));
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (lowest_oh[i]) begin
                pick_idx = pick_idx | evch_pkg::PORT_W'(i);
            end
        end
    end

    assign latch_new = !sel_reg[gsel];
    assign latch_cb  = latch_new && !upcall_masked_reg;

    assign sts.out_free    = !out_valid_reg || m_ready;
    assign sts.is_dispatch = (s_operation == evch_pkg::OP_DISPATCH);
    assign sts.start_empty = (snapshot == '0);
    assign sts.last_pick   = ((active_reg & ~lowest_oh) == '0);

    always_comb begin
        pending_next       = pending_reg;
        mask_next          = mask_reg;
        active_next        = active_reg;
        sel_next           = sel_reg;
        upcall_pend_next   = upcall_pend_reg;
        upcall_masked_next = upcall_masked_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        out_port_next      = out_port_reg;
        out_pv_next        = out_pv_reg;
        out_cb_next        = out_cb_reg;
        out_last_next      = out_last_reg;

        if (cmd.exec) begin
            out_valid_next = 1'b1;
            out_port_next  = '0;
            out_pv_next    = 1'b0;
            out_cb_next    = 1'b0;
            out_last_next  = 1'b1;
            unique case (s_operation)
                evch_pkg::OP_RAISE: begin
                    pending_next = pending_reg | port_bit;
                    if (port_ok && ((mask_reg & port_bit) == '0) && latch_new) begin
                        sel_next[gsel]   = 1'b1;
                        upcall_pend_next = 1'b1;
                        out_cb_next      = latch_cb;
                    end
                end
                evch_pkg::OP_MASK: begin
                    mask_next = mask_reg | port_bit;
                end
                evch_pkg::OP_UNMASK: begin
                    mask_next = mask_reg & ~port_bit;
                    if (port_ok && ((pending_reg & port_bit) != '0) && latch_new) begin
                        sel_next[gsel]   = 1'b1;
                        upcall_pend_next = 1'b1;
                        out_cb_next      = latch_cb;
                    end
                end
                evch_pkg::OP_CLEAR: begin
                    pending_next = pending_reg & ~port_bit;
                end
                evch_pkg::OP_DISPATCH: begin
                    upcall_pend_next = 1'b0;
                    sel_next         = '0;
                    active_next      = snapshot;
                    // A run with ports leaves the output to the emit steps.
                    out_valid_next   = (snapshot == '0);
                end
                evch_pkg::OP_UPCALL_SET: begin
                    upcall_masked_next = s_mask_level;
                    out_cb_next        = !s_mask_level && upcall_pend_reg;
                end
                default: begin
                end
            endcase
        end

        if (cmd.emit) begin
            pending_next   = pending_reg & ~lowest_oh;
            active_next    = active_reg & ~lowest_oh;
            out_valid_next = 1'b1;
            out_port_next  = pick_idx;
            out_pv_next    = 1'b1;
            out_cb_next    = 1'b0;
            out_last_next  = sts.last_pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg       <= '0;
            mask_reg          <= '1;
            sel_reg           <= '0;
            upcall_pend_reg   <= 1'b0;
            upcall_masked_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end else begin
            pending_reg       <= pending_next;
            mask_reg          <= mask_next;
            sel_reg           <= sel_next;
            upcall_pend_reg   <= upcall_pend_next;
            upcall_masked_reg <= upcall_masked_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        active_reg   <= active_next;
        out_port_reg <= out_port_next;
        out_pv_reg   <= out_pv_next;
        out_cb_reg   <= out_cb_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_dispatched_port  = out_port_reg;
    assign m_port_valid       = out_pv_reg;
    assign m_callback_request = out_cb_reg;
    assign m_last_of_run      = out_last_reg;

endmodule

// File: rtl/evch_checker.sv
// Port-level checker for the event channel block, bound to the top level.
// Depends on evch_pkg for field widths.
module evch_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [evch_pkg::PORT_W-1:0] m_dispatched_port,
    input logic                        m_port_valid,
    input logic                        m_callback_request,
    input logic                        m_last_of_run
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dispatched_port)
            && $stable(m_port_valid) && $stable(m_last_of_run))
        else $error("result word changed while stalled");

    // Dispatched ports never carry a callback request.
    a_port_no_cb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_port_valid |-> !m_callback_request)
        else $error("dispatched port carries a callback request");

    // A word without a port is always the only result of its run.
    a_noport_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_port_valid |-> m_last_of_run && (m_dispatched_port == '0))
        else $error("portless result is not a lone last word");

    // No new word is taken in the middle of a dispatch run.
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_port_valid && !m_last_of_run |-> !s_ready)
        else $error("input taken during a dispatch run");

endmodule

bind event_channel_pending_dispatch evch_checker u_evch_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_dispatched_port  (m_dispatched_port),
    .m_port_valid       (m_port_valid),
    .m_callback_request (m_callback_request),
    .m_last_of_run      (m_last_of_run)
);

// File: verif/event_channel_pending_dispatch_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_channel_pending_dispatch: directed and random command
// words against an in-bench predictor of the pending, mask and group selector state.
// Depends on evch_pkg and the event_channel_pending_dispatch RTL.
module event_channel_pending_dispatch_tb;

    localparam int PORTS     = 64;
    localparam int GROUP_BIT = 5;
    localparam int STALL_CAP = 4000;
    localparam int TAIL_WAIT = 20;

    // Operation codes the block does not define; they must be answered and ignored.
    localparam logic [evch_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [evch_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [evch_pkg::PORT_W-1:0] port;
        logic                        port_valid;
        logic                        callback;
        logic                        last;
    } delivery_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [evch_pkg::OP_W-1:0]   s_operation = '0;
    logic [evch_pkg::PORT_W-1:0] s_event_port = '0;
    logic                        s_mask_level = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [evch_pkg::PORT_W-1:0] m_dispatched_port;
    logic                        m_port_valid;
    logic                        m_callback_request;
    logic                        m_last_of_run;

    // Predicted block state.
    logic [PORTS-1:0]                pend_q;
    logic [PORTS-1:0]                mask_q;
    logic [evch_pkg::NUM_GROUPS-1:0] group_sel_q;
    logic                            upcall_pend_q;
    logic                            upcall_masked_q;

    delivery_t   pending_deliveries[$];
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned ports_delivered = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    event_channel_pending_dispatch #(
        .NUM_PORTS(PORTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_event_port(s_event_port),
        .s_mask_level(s_mask_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_dispatched_port(m_dispatched_port),
        .m_port_valid(m_port_valid),
        .m_callback_request(m_callback_request),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic latch_group(logic [evch_pkg::PORT_W-1:0] port);
        if (group_sel_q[port[GROUP_BIT]]) begin
            return 1'b0;
        end
        group_sel_q[port[GROUP_BIT]] = 1'b1;
        upcall_pend_q = 1'b1;
        return !upcall_masked_q;
    endfunction

    // Updates the predicted state for one word and queues the results it must produce.
    function automatic void predict_word(logic [evch_pkg::OP_W-1:0] op,
                                         logic [evch_pkg::PORT_W-1:0] port,
                                         logic level);
        logic                            cb;
        logic [evch_pkg::NUM_GROUPS-1:0] sel;
        int                              n;
        delivery_t                       w;
        cb = 1'b0;
        n  = 0;
        if (op == evch_pkg::OP_DISPATCH) begin
            sel = group_sel_q;
            upcall_pend_q = 1'b0;
            group_sel_q = '0;
            for (int g = 0; g < evch_pkg::NUM_GROUPS; g++) begin
                if (sel[g]) begin
                    for (int p = g * evch_pkg::GROUP_SIZE;
                         p < (g + 1) * evch_pkg::GROUP_SIZE; p++) begin
                        if (p < PORTS && pend_q[p] && !mask_q[p]) begin
                            pend_q[p] = 1'b0;
                            pending_deliveries.push_back(
                                '{evch_pkg::PORT_W'(p), 1'b1, 1'b0, 1'b0});
                            n++;
                        end
                    end
                end
            end
            if (n == 0) begin
                pending_deliveries.push_back('{'0, 1'b0, 1'b0, 1'b1});
            end else begin
                w = pending_deliveries.pop_back();
                w.last = 1'b1;
                pending_deliveries.push_back(w);
            end
        end else begin
            if (op == evch_pkg::OP_UPCALL_SET) begin
                if (level) begin
                    upcall_masked_q = 1'b1;
                end else begin
                    upcall_masked_q = 1'b0;
                    cb = upcall_pend_q;
                end
            end else if (int'(port) < PORTS) begin
                case (op)
                    evch_pkg::OP_RAISE: begin
                        pend_q[port] = 1'b1;
                        if (!mask_q[port]) cb = latch_group(port);
                    end
                    evch_pkg::OP_MASK: begin
                        mask_q[port] = 1'b1;
                    end
                    evch_pkg::OP_UNMASK: begin
                        mask_q[port] = 1'b0;
                        if (pend_q[port]) cb = latch_group(port);
                    end
                    evch_pkg::OP_CLEAR: begin
                        pend_q[port] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            pending_deliveries.push_back('{'0, 1'b0, cb, 1'b1});
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic [evch_pkg::OP_W-1:0] op,
                             logic [evch_pkg::PORT_W-1:0] port, logic level);
        while (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_event_port <= port;
        s_mask_level <= level;
        predict_word(op, port, level);
        words_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_deliveries.size() != 0) @(negedge aclk);
    endtask

    task automatic test_reset_state();
        send_word(evch_pkg::OP_DISPATCH, 6'd0, 1'b0);
        send_word(evch_pkg::OP_RAISE, 6'd5, 1'b0);
        send_word(evch_pkg::OP_UPCALL_SET, 6'd0, 1'b0);
    endtask

    task automatic test_latch_and_callback();
        send_word(evch_pkg::OP_UNMASK, 6'd5, 1'b0);
        send_word(evch_pkg::OP_RAISE, 6'd63, 1'b1);
        send_word(evch_pkg::OP_UNMASK, 6'd63, 1'b0);
        send_word(evch_pkg::OP_UNMASK, 6'd40, 1'b1);
        send_word(evch_pkg::OP_RAISE, 6'd40, 1'b0);
        send_word(evch_pkg::OP_UPCALL_SET, 6'd17, 1'b1);
        send_word(evch_pkg::OP_UPCALL_SET, 6'd0, 1'b0);
        send_word(evch_pkg::OP_UNMASK, 6'd0, 1'b0);
        send_word(evch_pkg::OP_RAISE, 6'd0, 1'b1);
    endtask

    task automatic test_dispatch_order();
        // Port 40 is pending but masked, so it must survive the dispatch.
        send_word(evch_pkg::OP_MASK, 6'd40, 1'b0);
        send_word(evch_pkg::OP_DISPATCH, 6'd63, 1'b1);
        send_word(evch_pkg::OP_DISPATCH, 6'd0, 1'b0);
        send_word(evch_pkg::OP_UNMASK, 6'd40, 1'b0);
        send_word(evch_pkg::OP_CLEAR, 6'd40, 1'b1);
        send_word(evch_pkg::OP_DISPATCH, 6'd21, 1'b0);
    endtask

    task automatic test_reserved_ops();
        send_word(OP_RESERVED_LO, 6'd63, 1'b1);
        send_word(OP_RESERVED_HI, 6'd0, 1'b0);
        send_word(OP_RESERVED_HI, 6'd42, 1'b1);
    endtask

    // Arms a set of ports and dispatches them; a size of 64 sweeps every port.
    task automatic run_burst(int unsigned size);
        logic [evch_pkg::PORT_W-1:0] base;
        logic [evch_pkg::PORT_W-1:0] p;
        base = evch_pkg::PORT_W'($urandom_range(PORTS - 1));
        if ($urandom_range(3) == 0) begin
            send_word(evch_pkg::OP_UPCALL_SET, evch_pkg::PORT_W'($urandom),
                      1'($urandom_range(1)));
        end
        for (int unsigned j = 0; j < size; j++) begin
            p = (size == PORTS) ? base + evch_pkg::PORT_W'(j)
                                : evch_pkg::PORT_W'($urandom_range(PORTS - 1));
            if ($urandom_range(1)) begin
                send_word(evch_pkg::OP_UNMASK, p, 1'($urandom_range(1)));
                send_word(evch_pkg::OP_RAISE, p, 1'($urandom_range(1)));
            end else begin
                send_word(evch_pkg::OP_RAISE, p, 1'($urandom_range(1)));
                send_word(evch_pkg::OP_UNMASK, p, 1'($urandom_range(1)));
            end
            if ($urandom_range(9) == 0) begin
                send_word($urandom_range(1) ? evch_pkg::OP_MASK : evch_pkg::OP_CLEAR, p,
                          1'($urandom_range(1)));
            end
        end
        send_word(evch_pkg::OP_DISPATCH, evch_pkg::PORT_W'($urandom),
                  1'($urandom_range(1)));
    endtask

    task automatic test_drain_pause();
        run_burst(3);
        wait_for_drain();
        @(negedge aclk);
        send_word(evch_pkg::OP_DISPATCH, 6'd9, 1'b0);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned stop_at;
        bit          swept;
        stop_at = words_sent + count;
        swept   = 1'b0;
        while (words_sent < stop_at) begin
            calm = (words_sent >= stop_at - count / 2) && (words_sent < stop_at - count / 4);
            if ($urandom_range(9) < 6) begin
                if (!swept || $urandom_range(60) == 0) begin
                    swept = 1'b1;
                    run_burst(PORTS);
                end else begin
                    run_burst($urandom_range(1, 6));
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(evch_pkg::OP_W'($urandom_range(7)),
                              evch_pkg::PORT_W'($urandom), 1'($urandom_range(1)));
                end
            end
            if ($urandom_range(19) == 0) wait_for_drain();
        end
        calm = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end

    // Each result word is compared with the oldest prediction.
    always @(posedge aclk) begin
        delivery_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_deliveries.size() == 0) begin
                $error("unexpected result word: port %0d valid %0b cb %0b last %0b",
                       m_dispatched_port, m_port_valid, m_callback_request, m_last_of_run);
                errors++;
            end else begin
                w = pending_deliveries.pop_front();
                if (m_port_valid) ports_delivered++;
                if (m_dispatched_port !== w.port) begin
                    $error("dispatched_port: expected %0d, got %0d", w.port, m_dispatched_port);
                    errors++;
                end
                if (m_port_valid !== w.port_valid) begin
                    $error("port_valid: expected %0b, got %0b", w.port_valid, m_port_valid);
                    errors++;
                end
                if (m_callback_request !== w.callback) begin
                    $error("callback_request: expected %0b, got %0b", w.callback,
                           m_callback_request);
                    errors++;
                end
                if (m_last_of_run !== w.last) begin
                    $error("last_of_run: expected %0b, got %0b", w.last, m_last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_CAP) begin
                $display("event_channel_pending_dispatch verification failed");
                $finish;
            end
        end
    end

    initial begin
        pend_q          = '0;
        mask_q          = '1;
        group_sel_q     = '0;
        upcall_pend_q   = 1'b0;
        upcall_masked_q = 1'b1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_latch_and_callback();
        test_dispatch_order();
        test_reserved_ops();
        test_drain_pause();
        test_random_traffic(330);

        wait_for_drain();
        repeat (TAIL_WAIT) @(posedge aclk);
        $display("Sent %0d command words and checked %0d result words.", words_sent,
                 results_seen);
        $display("Dispatch runs delivered %0d ports, including a sweep of all %0d.",
                 ports_delivered, PORTS);
        if (errors == 0 && pending_deliveries.size() == 0) begin
            $display("event_channel_pending_dispatch verification clean");
        end else begin
            $display("event_channel_pending_dispatch verification failed");
        end
        $finish;
    end

endmodule
